FILE: design/ale_pkg.sv
`default_nettype none
package ale_pkg;

  localparam int CAPACITY = 256;
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = 9;
  localparam int DW = 32;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_LOCATE = 3'd3;
  localparam logic [2:0] CMD_DEDUP  = 3'd4;
  localparam logic [2:0] CMD_SORT   = 3'd5;
  localparam logic [2:0] CMD_READ   = 3'd6;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [2:0]           command;
    logic signed [DW-1:0] value;
    logic [LW-1:0]        position;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [LW-1:0]        found_position;
    logic signed [DW-1:0] read_value;
    logic [LW-1:0]        list_length;
  } out_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

FILE: design/ale_store.sv
`default_nettype none
module ale_store (
  input  logic                       clk_i,
  input  ale_pkg::mem_req_t          req_i,
  output logic [ale_pkg::DW-1:0]     rdata_o
);
  import ale_pkg::*;

  logic [DW-1:0] mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule
`default_nettype wire

FILE: design/array_list_engine_core.sv
`default_nettype none
// channel   direction  payload  handshake
// in        input      in_t     in_valid_i / in_stall_o
// out       output     out_t    out_valid_o / out_stall_i
//
// one command at a time; the store is a single-port-read ram with registered
// read data, so each element access needs a read state ahead of its use
// sort and duplicate removal: every compare goes through one comparator
// reset (async, active low) empties the list; store contents stay undefined
// input is stalled while a command runs or while a result waits for transfer
module array_list_engine_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ale_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ale_pkg::out_t   out_data_o
);
  import ale_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_WR, S_INS_PUT, S_DEL_RD, S_DEL_WR,
    S_LOC_RD, S_LOC_CMP, S_DD_TOP, S_DD_GETI, S_DD_RDJ, S_DD_CMPJ, S_DD_KEEP,
    S_SO_TOP, S_SO_GETI, S_SO_J, S_SO_CMP, S_RD_GET
  } state_e;

  state_e        state_q;
  logic [LW-1:0] len_q, idx_q, jdx_q, kept_q, pos_q;
  logic [DW-1:0] cur_q;
  out_t          out_q;
  logic          out_valid_q;

  mem_req_t      req;
  logic [DW-1:0] rdata;

  // shared compare unit
  logic eq, gt;
  assign eq = (rdata == cur_q);
  assign gt = ($signed(cur_q) > $signed(rdata));

  logic          in_xfer;
  logic [LW-1:0] idx_m1, idx_p1, jdx_p1, pos_in_m1;
  logic [LW:0]   len_p1;
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign idx_m1    = idx_q - LW'(1);
  assign idx_p1    = idx_q + LW'(1);
  assign jdx_p1    = jdx_q + LW'(1);
  assign pos_in_m1 = in_data_i.position - LW'(1);
  assign len_p1    = {1'b0, len_q} + (LW+1)'(1);

  // memory request decode
  always_comb begin
    req       = '0;
    req.wdata = cur_q;
    unique case (state_q)
      S_IDLE:    req.raddr = pos_in_m1[AW-1:0];
      S_INS_RD:  req.raddr = idx_m1[AW-1:0];
      S_INS_WR: begin
        req.we    = 1'b1;
        req.waddr = idx_q[AW-1:0];
        req.wdata = rdata;
      end
      S_INS_PUT: begin
        req.we    = 1'b1;
        req.waddr = pos_q[AW-1:0];
      end
      S_DEL_RD:  req.raddr = idx_p1[AW-1:0];
      S_DEL_WR: begin
        req.we    = 1'b1;
        req.waddr = idx_q[AW-1:0];
        req.wdata = rdata;
      end
      S_LOC_RD, S_DD_TOP, S_SO_TOP: req.raddr = idx_q[AW-1:0];
      S_DD_RDJ:  req.raddr = jdx_q[AW-1:0];
      S_DD_KEEP: begin
        req.we    = 1'b1;
        req.waddr = kept_q[AW-1:0];
      end
      S_SO_J: begin
        if (jdx_q < len_q) begin
          req.raddr = jdx_q[AW-1:0];
        end else begin
          // park the running minimum at slot i
          req.we    = 1'b1;
          req.waddr = idx_q[AW-1:0];
        end
      end
      S_SO_CMP: begin
        req.we    = gt;
        req.waddr = jdx_q[AW-1:0];
      end
      default: ;
    endcase
  end

  ale_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      jdx_q       <= '0;
      kept_q      <= '0;
      pos_q       <= '0;
      cur_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            out_q.found_position <= '0;
            out_q.read_value     <= '0;
            out_q.list_length    <= (in_data_i.command == CMD_CLEAR) ? '0 : len_q;
            cur_q       <= in_data_i.value;
            pos_q       <= pos_in_m1;
            idx_q       <= '0;
            kept_q      <= '0;
            case (in_data_i.command)
              CMD_CLEAR: begin
                len_q        <= '0;
                out_q.status <= ST_OK;
                out_valid_q  <= 1'b1;
              end
              CMD_INSERT: begin
                if (len_q >= LW'(CAPACITY)) begin
                  out_q.status <= ST_FULL;
                  out_valid_q  <= 1'b1;
                end else if (in_data_i.position == '0 ||
                             {1'b0, in_data_i.position} > len_p1) begin
                  out_q.status <= ST_BADPOS;
                  out_valid_q  <= 1'b1;
                end else begin
                  out_q.status <= ST_OK;
                  idx_q        <= len_q;
                  state_q      <= (len_q > pos_in_m1) ? S_INS_RD : S_INS_PUT;
                end
              end
              CMD_DELETE, CMD_READ: begin
                if (len_q == '0) begin
                  out_q.status <= ST_EMPTY;
                  out_valid_q  <= 1'b1;
                end else if (in_data_i.position == '0 || in_data_i.position > len_q) begin
                  out_q.status <= ST_BADPOS;
                  out_valid_q  <= 1'b1;
                end else begin
                  out_q.status <= ST_OK;
                  idx_q        <= pos_in_m1;
                  state_q <= (in_data_i.command == CMD_READ) ? S_RD_GET : S_DEL_RD;
                end
              end
              CMD_LOCATE: begin
                out_q.status <= ST_OK;
                state_q      <= S_LOC_RD;
              end
              CMD_DEDUP: begin
                out_q.status <= ST_OK;
                state_q      <= S_DD_TOP;
              end
              CMD_SORT: begin
                out_q.status <= ST_OK;
                state_q      <= S_SO_TOP;
              end
              default: begin
                out_q.status <= ST_OK;
                out_valid_q  <= 1'b1;
              end
            endcase
          end
        end
        // insert: shift entries up from the tail, then drop in the value
        S_INS_RD: state_q <= S_INS_WR;
        S_INS_WR: begin
          idx_q   <= idx_m1;
          state_q <= ((idx_q - LW'(2)) >= pos_q && idx_m1 != pos_q) ? S_INS_RD : S_INS_PUT;
        end
        S_INS_PUT: begin
          len_q             <= len_q + LW'(1);
          out_q.list_length <= len_q + LW'(1);
          out_valid_q       <= 1'b1;
          state_q           <= S_IDLE;
        end
        // delete: pull later entries down one slot
        S_DEL_RD: begin
          if (idx_p1 < len_q) begin
            state_q <= S_DEL_WR;
          end else begin
            len_q             <= len_q - LW'(1);
            out_q.list_length <= len_q - LW'(1);
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        S_DEL_WR: begin
          idx_q   <= idx_p1;
          state_q <= S_DEL_RD;
        end
        S_LOC_RD: begin
          if (idx_q < len_q) begin
            state_q <= S_LOC_CMP;
          end else begin
            out_q.found_position <= len_p1[LW-1:0];
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        S_LOC_CMP: begin
          if (eq) begin
            out_q.found_position <= idx_p1;
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end else begin
            idx_q   <= idx_p1;
            state_q <= S_LOC_RD;
          end
        end
        // duplicate removal: compare entry i against the kept entries until a match
        S_DD_TOP: begin
          if (idx_q < len_q) begin
            state_q <= S_DD_GETI;
          end else begin
            len_q             <= kept_q;
            out_q.list_length <= kept_q;
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        S_DD_GETI: begin
          cur_q   <= rdata;
          jdx_q   <= '0;
          state_q <= (kept_q != '0) ? S_DD_RDJ : S_DD_KEEP;
        end
        S_DD_RDJ: state_q <= S_DD_CMPJ;
        S_DD_CMPJ: begin
          if (eq) begin
            idx_q   <= idx_p1;
            state_q <= S_DD_TOP;
          end else begin
            jdx_q   <= jdx_p1;
            state_q <= (jdx_p1 < kept_q) ? S_DD_RDJ : S_DD_KEEP;
          end
        end
        S_DD_KEEP: begin
          kept_q  <= kept_q + LW'(1);
          idx_q   <= idx_p1;
          state_q <= S_DD_TOP;
        end
        // exchange sort: running minimum of slot i held in cur_q
        S_SO_TOP: begin
          if (idx_q < len_q) begin
            state_q <= S_SO_GETI;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_SO_GETI: begin
          cur_q   <= rdata;
          jdx_q   <= idx_p1;
          state_q <= S_SO_J;
        end
        S_SO_J: begin
          if (jdx_q < len_q) begin
            state_q <= S_SO_CMP;
          end else begin
            idx_q   <= idx_p1;
            state_q <= S_SO_TOP;
          end
        end
        S_SO_CMP: begin
          if (gt) begin
            cur_q <= rdata;
          end
          jdx_q   <= jdx_p1;
          state_q <= S_SO_J;
        end
        S_RD_GET: begin
          out_q.read_value <= rdata;
          out_valid_q      <= 1'b1;
          state_q          <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // length never exceeds the store
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LW'(CAPACITY))
    else $error("list length beyond capacity");

  // an accepted command is either in progress or has its result posted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != S_IDLE) || out_valid_q)
    else $error("command dropped");

  // a result is only posted once the sequencer is back home
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == S_IDLE)
    else $error("result posted while busy");

  // the store is never written while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> state_q != S_IDLE)
    else $error("store write while idle");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ale_pkg::*;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_stall_i;
  out_t  out_data_o;

  array_list_engine_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // predictor state: shadow list and its length
  logic [DW-1:0] shadow_list [CAPACITY];
  int unsigned   shadow_len;
  out_t          pending_results [$];
  int unsigned   mismatch_count;
  int unsigned   sent_count;
  bit            hold_off;   // long receiver hold-off request

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  // apply one command to the shadow list, return the result it gives
  function automatic out_t list_apply(in_t cmd);
    out_t          r;
    int unsigned   n;
    int unsigned   p;
    int unsigned   kept;
    bit            dup;
    logic [DW-1:0] t;
    r = '0;
    n = shadow_len;
    p = cmd.position;
    r.status = ST_OK;
    case (cmd.command)
      CMD_CLEAR: n = 0;
      CMD_INSERT: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else if (p < 1 || p > n + 1) r.status = ST_BADPOS;
        else begin
          for (int i = n; i > p - 1; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p-1] = cmd.value;
          n++;
        end
      end
      CMD_DELETE: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (p < 1 || p > n) r.status = ST_BADPOS;
        else begin
          for (int i = p - 1; i + 1 < n; i++) shadow_list[i] = shadow_list[i+1];
          n--;
        end
      end
      CMD_LOCATE: begin
        r.found_position = LW'(n + 1);
        for (int i = 0; i < n; i++)
          if (shadow_list[i] == cmd.value) begin
            r.found_position = LW'(i + 1);
            break;
          end
      end
      CMD_DEDUP: begin
        kept = 0;
        for (int i = 0; i < n; i++) begin
          dup = 1'b0;
          for (int j = 0; j < kept; j++)
            if (shadow_list[j] == shadow_list[i]) dup = 1'b1;
          if (!dup) begin
            shadow_list[kept] = shadow_list[i];
            kept++;
          end
        end
        n = kept;
      end
      CMD_SORT: begin
        for (int i = 0; i < n; i++)
          for (int j = i + 1; j < n; j++)
            if ($signed(shadow_list[i]) > $signed(shadow_list[j])) begin
              t = shadow_list[i];
              shadow_list[i] = shadow_list[j];
              shadow_list[j] = t;
            end
      end
      CMD_READ: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (p < 1 || p > n) r.status = ST_BADPOS;
        else r.read_value = shadow_list[p-1];
      end
      default: ;
    endcase
    shadow_len = n;
    r.list_length = LW'(n);
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one transfer and wait until it is taken; valid stays up into the
  // next call when there is no gap
  task automatic send_cmd(in_t cmd);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(list_apply(cmd));
    sent_count++;
    @(negedge clk_i);
  endtask

  function automatic in_t mk(logic [2:0] c, logic [DW-1:0] v, logic [LW-1:0] p);
    in_t x;
    x.command = c;
    x.value = v;
    x.position = p;
    return x;
  endfunction

  // random command: mostly valid positions, some out of range
  function automatic in_t rand_cmd(int unsigned fill_bias);
    in_t         x;
    int unsigned k;
    int unsigned n;
    n = shadow_len;
    x.value = $urandom;
    if ($urandom_range(0, 2) == 0 && n > 0) x.value = shadow_list[$urandom_range(0, n-1)];
    if ($urandom_range(0, 3) == 0) x.value = $signed($urandom_range(0, 6)) - 3;
    k = $urandom_range(0, 99);
    if (k < fill_bias) x.command = CMD_INSERT;
    else if (k < fill_bias + 12) x.command = CMD_DELETE;
    else if (k < fill_bias + 24) x.command = CMD_READ;
    else if (k < fill_bias + 34) x.command = CMD_LOCATE;
    else if (k < fill_bias + 37) x.command = CMD_SORT;
    else if (k < fill_bias + 40) x.command = CMD_DEDUP;
    else if (k < fill_bias + 41) x.command = CMD_CLEAR;
    else if (k < fill_bias + 42) x.command = CMD_UNUSED;
    else x.command = CMD_READ;
    if ($urandom_range(0, 9) == 0) x.position = LW'($urandom_range(0, 511));
    else x.position = LW'($urandom_range(1, n + 1));
    return x;
  endfunction

  typedef struct {
    in_t  cmd;
    bit   has_exp;
    out_t exp;
  } step_t;

  // expected values typed in only where obvious
  function automatic out_t ex(logic [1:0] s, logic [LW-1:0] f, logic [DW-1:0] v,
                              logic [LW-1:0] l);
    out_t r;
    r.status = s;
    r.found_position = f;
    r.read_value = v;
    r.list_length = l;
    return r;
  endfunction

  // stimulus: directed table, then random
  initial begin
    step_t directed [$];
    out_t  hand;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    rst_ni      = 1'b0;
    shadow_len  = 0;
    sent_count  = 0;
    hold_off    = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed = '{
      '{mk(CMD_READ,   0, 1),          1, ex(ST_EMPTY, 0, 0, 0)},
      '{mk(CMD_DELETE, 0, 1),          1, ex(ST_EMPTY, 0, 0, 0)},
      '{mk(CMD_LOCATE, 5, 0),          1, ex(ST_OK, 1, 0, 0)},
      '{mk(CMD_DEDUP,  0, 0),          1, ex(ST_OK, 0, 0, 0)},
      '{mk(CMD_SORT,   0, 0),          1, ex(ST_OK, 0, 0, 0)},
      '{mk(CMD_INSERT, 1, 0),          1, ex(ST_BADPOS, 0, 0, 0)},
      '{mk(CMD_INSERT, 1, 2),          1, ex(ST_BADPOS, 0, 0, 0)},
      '{mk(CMD_INSERT, 32'h7fffffff, 1), 1, ex(ST_OK, 0, 0, 1)},
      '{mk(CMD_INSERT, 32'h80000000, 2), 1, ex(ST_OK, 0, 0, 2)},
      '{mk(CMD_INSERT, 32'h7fffffff, 1), 0, '0},
      '{mk(CMD_INSERT, 32'hffffffff, 4), 0, '0},
      '{mk(CMD_READ,   0, 0),          1, ex(ST_BADPOS, 0, 0, 4)},
      '{mk(CMD_READ,   0, 5),          1, ex(ST_BADPOS, 0, 0, 4)},
      '{mk(CMD_READ,   0, 511),        1, ex(ST_BADPOS, 0, 0, 4)},
      '{mk(CMD_DELETE, 0, 5),          1, ex(ST_BADPOS, 0, 0, 4)},
      '{mk(CMD_LOCATE, 32'h80000000, 0), 0, '0},
      '{mk(CMD_LOCATE, 12345, 0),      1, ex(ST_OK, 5, 0, 4)},
      '{mk(CMD_SORT,   0, 0),          0, '0},
      '{mk(CMD_READ,   0, 1),          1, ex(ST_OK, 0, 32'h80000000, 4)},
      '{mk(CMD_DEDUP,  0, 0),          0, '0},
      '{mk(CMD_UNUSED, -1, 511),       0, '0},
      '{mk(CMD_DELETE, 0, 1),          0, '0},
      '{mk(CMD_READ,   0, 2),          0, '0},
      '{mk(CMD_CLEAR,  0, 0),          1, ex(ST_OK, 0, 0, 0)}
    };
    foreach (directed[i]) begin
      send_cmd(directed[i].cmd);
      if (directed[i].has_exp) begin
        hand = directed[i].exp;
        if (hand !== pending_results[$]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("table row %0d disagrees with predictor: %p vs %p",
                     i, hand, pending_results[$]);
        end
      end
    end

    // fill to full, then hit full, with a long receiver hold-off at the start
    hold_off = 1'b1;
    while (shadow_len < CAPACITY)
      send_cmd(mk(CMD_INSERT, $urandom_range(0, 40), LW'($urandom_range(1, shadow_len + 1))));
    send_cmd(mk(CMD_INSERT, 0, 1));
    send_cmd(mk(CMD_DEDUP, 0, 0));
    send_cmd(mk(CMD_CLEAR, 0, 0));

    // random: bias toward insert keeps lists mostly short to medium
    repeat (220) begin
      if (shadow_len > 40) send_cmd(rand_cmd(10));
      else send_cmd(rand_cmd(40));
    end
    in_valid_i <= 1'b0;

    begin
      int unsigned waited;
      waited = 0;
      while (pending_results.size() != 0 && waited < 2000000) begin
        @(posedge clk_i);
        waited++;
      end
      repeat (100000) begin
        @(posedge clk_i);
        if (pending_results.size() == 0 && !out_valid_o) break;
      end
      repeat (20) @(posedge clk_i);
    end
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // receiver stall: random gaps, plus one long hold-off counted here
  initial begin
    int unsigned g;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(negedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g == 0 || $urandom_range(0, 3) == 0) out_stall_i <= 1'b0;
      else begin
        out_stall_i <= 1'b1;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  // result checker: each transfer against the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transfer: %p", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status ||
            out_data_o.found_position !== want.found_position ||
            out_data_o.read_value !== want.read_value ||
            out_data_o.list_length !== want.list_length) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p got %p", want, out_data_o);
        end
      end
    end
  end

  initial mismatch_count = 0;

endmodule
